[rtl/gsca_pkg.sv]
// Package for the glyph shelf cache allocator: sizes, codes, tables and the
// command and status structs between controller and datapath. No dependencies.
package gsca_pkg;

    localparam int SHELF_WIDTH       = 1024;
    localparam int SHELVES_PER_CLASS = 4;
    localparam int NUM_CLASSES       = 10;
    localparam int STORE_DEPTH       = NUM_CLASSES * SHELVES_PER_CLASS;
    localparam int OVERSIZE_CLASS    = 9;
    localparam int MAX_EVICT         = 40;

    localparam int CLS_W  = $clog2(NUM_CLASSES);
    localparam int SLOT_W = $clog2(SHELVES_PER_CLASS) > 0 ? $clog2(SHELVES_PER_CLASS) : 1;
    localparam int CNT_W  = $clog2(SHELVES_PER_CLASS + 1);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int EVC_W  = $clog2(MAX_EVICT + 1);
    // store entry: id, width, height
    localparam int ENTRY_W = 32 + 11 + 12;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR   = 2'd1;
    localparam logic [1:0] FUNC_ENFORCE = 2'd2;

    localparam logic [2:0] ST_EXISTING = 3'd0;
    localparam logic [2:0] ST_NEW      = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_CLEARED  = 3'd3;
    localparam logic [2:0] ST_EVICTED  = 3'd4;
    localparam logic [2:0] ST_NONE     = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC_RD,
        S_ALLOC_DO,
        S_EV_CHECK,
        S_EV_SCAN,
        S_EV_RD,
        S_EV_MUL,
        S_EV_DO,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;   // capture input beat
        logic alloc_rd;    // issue store read for the newest shelf
        logic alloc_do;    // decide and update for allocate
        logic do_clear;
        logic ev_start;    // reset scan and result count
        logic scan_step;   // examine one class
        logic ev_rd;       // read head entry of chosen class
        logic ev_mul;      // multiply area
        logic ev_do;       // retire oldest shelf
        logic res_none;    // load nothing-evicted result
        logic res_clear;   // load cleared result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       over_limit;  // limit nonzero and total above it
        logic       scan_done;
        logic       found;
        logic       ev_max;      // eviction count reached
        logic       evicted_any;
        logic       any_live;    // some class holds a shelf
    } dp_stat_t;

    function automatic logic [11:0] class_height(input logic [CLS_W-1:0] c);
        logic [11:0] h;
        case (c)
            4'd0:    h = 12'd8;
            4'd1:    h = 12'd12;
            4'd2:    h = 12'd16;
            4'd3:    h = 12'd24;
            4'd4:    h = 12'd32;
            4'd5:    h = 12'd48;
            4'd6:    h = 12'd64;
            4'd7:    h = 12'd96;
            default: h = 12'd128;
        endcase
        return h;
    endfunction

    function automatic logic [CLS_W-1:0] height_class(input logic [11:0] h);
        logic [CLS_W-1:0] c;
        if (h > 12'd128)      c = CLS_W'(OVERSIZE_CLASS);
        else if (h <= 12'd8)  c = CLS_W'(0);
        else if (h <= 12'd12) c = CLS_W'(1);
        else if (h <= 12'd16) c = CLS_W'(2);
        else if (h <= 12'd24) c = CLS_W'(3);
        else if (h <= 12'd32) c = CLS_W'(4);
        else if (h <= 12'd48) c = CLS_W'(5);
        else if (h <= 12'd64) c = CLS_W'(6);
        else if (h <= 12'd96) c = CLS_W'(7);
        else                  c = CLS_W'(8);
        return c;
    endfunction

endpackage

[rtl/gsca_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module gsca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/gsca_ctrl.sv]
// Controller state machine for the glyph shelf cache allocator.
// Depends on gsca_pkg.
module gsca_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_last,
    input  gsca_pkg::dp_stat_t stat,
    output gsca_pkg::dp_cmd_t  cmd
);

    gsca_pkg::state_t state_reg, state_next;
    logic last_reg, last_next;
    logic ret_reg, ret_next;  // eviction result held in the output register

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gsca_pkg::S_IDLE;
            last_reg  <= 1'b0;
            ret_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            ret_reg   <= ret_next;
        end
    end

    assign in_ready  = (state_reg == gsca_pkg::S_IDLE);
    assign out_valid = (state_reg == gsca_pkg::S_OUT);
    // eviction result: last when no further eviction follows the updated state
    assign out_last  = ret_reg ? (!stat.over_limit || stat.ev_max || !stat.any_live) :
                       last_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        unique case (state_reg)
            gsca_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = gsca_pkg::S_ALLOC_RD;
                end
            end
            gsca_pkg::S_ALLOC_RD:
            begin
                unique case (stat.func)
                    gsca_pkg::FUNC_ALLOC:
                    begin
                        cmd.alloc_rd = 1'b1;
                        state_next   = gsca_pkg::S_ALLOC_DO;
                    end
                    gsca_pkg::FUNC_CLEAR:
                    begin
                        cmd.do_clear  = 1'b1;
                        cmd.res_clear = 1'b1;
                        last_next     = 1'b1;
                        ret_next      = 1'b0;
                        state_next    = gsca_pkg::S_OUT;
                    end
                    gsca_pkg::FUNC_ENFORCE:
                    begin
                        cmd.ev_start = 1'b1;
                        state_next   = gsca_pkg::S_EV_CHECK;
                    end
                    default: state_next = gsca_pkg::S_IDLE;
                endcase
            end
            gsca_pkg::S_ALLOC_DO:
            begin
                cmd.alloc_do = 1'b1;
                last_next    = 1'b1;
                ret_next     = 1'b0;
                state_next   = gsca_pkg::S_OUT;
            end
            gsca_pkg::S_EV_CHECK:
            begin
                if (stat.over_limit && !stat.ev_max)
                begin
                    state_next = gsca_pkg::S_EV_SCAN;
                end
                else if (!stat.evicted_any)
                begin
                    cmd.res_none = 1'b1;
                    last_next    = 1'b1;
                    ret_next     = 1'b0;
                    state_next   = gsca_pkg::S_OUT;
                end
                else
                begin
                    state_next = gsca_pkg::S_IDLE;
                end
            end
            gsca_pkg::S_EV_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    if (stat.found)
                    begin
                        state_next = gsca_pkg::S_EV_RD;
                    end
                    else if (!stat.evicted_any)
                    begin
                        cmd.res_none = 1'b1;
                        last_next    = 1'b1;
                        ret_next     = 1'b0;
                        state_next   = gsca_pkg::S_OUT;
                    end
                    else
                    begin
                        state_next = gsca_pkg::S_IDLE;
                    end
                end
            end
            gsca_pkg::S_EV_RD:
            begin
                cmd.ev_rd  = 1'b1;
                state_next = gsca_pkg::S_EV_MUL;
            end
            gsca_pkg::S_EV_MUL:
            begin
                cmd.ev_mul = 1'b1;
                state_next = gsca_pkg::S_EV_DO;
            end
            gsca_pkg::S_EV_DO:
            begin
                cmd.ev_do = 1'b1;
                // last follows from the updated total and class counts
                last_next  = 1'b0;
                ret_next   = 1'b1;
                state_next = gsca_pkg::S_OUT;
            end
            gsca_pkg::S_OUT:
            begin
                if (out_ready)
                begin
                    if (out_last)
                    begin
                        state_next = gsca_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = gsca_pkg::S_EV_SCAN;
                    end
                end
            end
            default: state_next = gsca_pkg::S_IDLE;
        endcase
    end

endmodule

[rtl/gsca_dp.sv]
// Datapath for the glyph shelf cache allocator: class state, shelf store,
// pixel total, oldest-shelf scan and result register. Depends on gsca_pkg, gsca_ram.
module gsca_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [30:0]        cfg_wdata,
    input  logic [1:0]         in_func,
    input  logic [10:0]        in_width,
    input  logic [11:0]        in_height,
    input  gsca_pkg::dp_cmd_t  cmd,
    output gsca_pkg::dp_stat_t stat,
    output logic [2:0]         res_status,
    output logic [31:0]        res_number,
    output logic [10:0]        res_x,
    output logic [10:0]        res_w,
    output logic [11:0]        res_h
);

    localparam int CW = gsca_pkg::CLS_W;
    localparam int SW = gsca_pkg::SLOT_W;
    localparam int NW = gsca_pkg::CNT_W;
    localparam int AW = gsca_pkg::ADDR_W;
    localparam int SPC = gsca_pkg::SHELVES_PER_CLASS;

    logic [30:0] limit_reg;
    logic [1:0]  func_reg;
    logic [10:0] w_reg;
    logic [11:0] h_reg;
    logic [CW-1:0] cls_reg;

    logic [SW-1:0] head_reg [gsca_pkg::NUM_CLASSES];
    logic [NW-1:0] count_reg [gsca_pkg::NUM_CLASSES];
    logic [10:0]   used_reg [gsca_pkg::NUM_CLASSES];
    logic [31:0]   total_reg;
    logic [31:0]   next_num_reg;

    logic [CW-1:0] scan_reg;
    logic          found_reg;
    logic [CW-1:0] best_reg;
    logic [31:0]   best_age_reg;
    logic          scan_rd_reg;   // scan read in flight for class scan_cls_reg
    logic [CW-1:0] scan_cls_reg;
    logic [gsca_pkg::EVC_W-1:0] evc_reg;
    logic [22:0]   prod_reg;

    // store port
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [gsca_pkg::ENTRY_W-1:0] wdata, rdata;
    logic [31:0]   rd_id;
    logic [10:0]   rd_w;
    logic [11:0]   rd_h;

    gsca_ram #(.WIDTH(gsca_pkg::ENTRY_W), .DEPTH(gsca_pkg::STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd_id = rdata[54:23];
    assign rd_w  = rdata[22:12];
    assign rd_h  = rdata[11:0];

    function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] c,
                                                input logic [SW-1:0] s);
        return AW'(c * SPC) + AW'(s);
    endfunction

    function automatic logic [SW-1:0] ring(input logic [SW-1:0] hd, input logic [NW-1:0] n);
        logic [NW:0] t;
        t = (NW+1)'(hd) + (NW+1)'(n);
        if (t >= (NW+1)'(SPC)) t = t - (NW+1)'(SPC);
        return SW'(t);
    endfunction

    // allocate decisions
    logic [NW-1:0] cnt_c;
    logic [SW-1:0] head_c;
    logic [11:0]   fit_sum;
    logic          fits, full;
    logic [10:0]   new_w;
    logic [11:0]   new_h;
    logic [22:0]   new_area;

    assign cnt_c   = count_reg[cls_reg];
    assign head_c  = head_reg[cls_reg];
    assign fit_sum = {1'b0, used_reg[cls_reg]} + {1'b0, w_reg};
    assign fits    = (cls_reg != CW'(gsca_pkg::OVERSIZE_CLASS)) && (cnt_c != '0) &&
                     (fit_sum <= 12'(gsca_pkg::SHELF_WIDTH));
    assign full    = (cnt_c >= NW'(SPC));
    assign new_w   = (cls_reg == CW'(gsca_pkg::OVERSIZE_CLASS)) ? w_reg :
                     11'(gsca_pkg::SHELF_WIDTH);
    assign new_h   = (cls_reg == CW'(gsca_pkg::OVERSIZE_CLASS)) ? h_reg :
                     gsca_pkg::class_height(cls_reg);
    assign new_area = new_w * new_h;

    // store address and write
    always_comb
    begin
        we    = 1'b0;
        waddr = slot_addr(cls_reg, ring(head_c, cnt_c));
        wdata = {next_num_reg, new_w, new_h};
        raddr = slot_addr(cls_reg, ring(head_c, cnt_c - NW'(1)));
        if (cmd.alloc_do && !fits && !full)
        begin
            we = 1'b1;
        end
        if (cmd.scan_step)
        begin
            raddr = slot_addr(scan_reg, head_reg[scan_reg]);
        end
        else if (cmd.ev_rd)
        begin
            raddr = slot_addr(best_reg, head_reg[best_reg]);
        end
    end

    // any class still holding a shelf
    logic any_live;
    always_comb
    begin
        any_live = 1'b0;
        for (int i = 0; i < gsca_pkg::NUM_CLASSES; i++)
        begin
            if (count_reg[i] != '0)
            begin
                any_live = 1'b1;
            end
        end
    end

    logic [31:0] age;
    assign age = next_num_reg - rd_id;

    assign stat.func        = func_reg;
    assign stat.over_limit  = (limit_reg != '0) && (total_reg > {1'b0, limit_reg});
    assign stat.scan_done   = scan_rd_reg &&
                              (scan_cls_reg == CW'(gsca_pkg::NUM_CLASSES - 1));
    assign stat.found       = found_reg || (scan_rd_reg &&
                              count_reg[scan_cls_reg] != '0);
    assign stat.ev_max      = (evc_reg == gsca_pkg::EVC_W'(gsca_pkg::MAX_EVICT));
    assign stat.evicted_any = (evc_reg != '0);
    assign stat.any_live    = any_live;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= '0;
            func_reg     <= '0;
            total_reg    <= '0;
            next_num_reg <= '0;
            scan_reg     <= '0;
            scan_rd_reg  <= 1'b0;
            scan_cls_reg <= '0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            best_age_reg <= '0;
            evc_reg      <= '0;
            for (int i = 0; i < gsca_pkg::NUM_CLASSES; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
                used_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.load_item)
            begin
                func_reg <= in_func;
            end
            if (cmd.do_clear)
            begin
                total_reg <= '0;
                for (int i = 0; i < gsca_pkg::NUM_CLASSES; i++)
                begin
                    head_reg[i]  <= '0;
                    count_reg[i] <= '0;
                    used_reg[i]  <= '0;
                end
            end
            if (cmd.alloc_do)
            begin
                if (fits)
                begin
                    used_reg[cls_reg] <= fit_sum[10:0];
                end
                else if (!full)
                begin
                    next_num_reg       <= next_num_reg + 32'd1;
                    count_reg[cls_reg] <= cnt_c + NW'(1);
                    total_reg          <= total_reg + 32'(new_area);
                    used_reg[cls_reg]  <= w_reg;
                end
            end
            if (cmd.ev_start)
            begin
                evc_reg <= '0;
            end
            // oldest scan: one class read per cycle, compared in the cycle after its read
            if (cmd.ev_start || cmd.ev_do)
            begin
                scan_reg    <= '0;
                scan_rd_reg <= 1'b0;
                found_reg   <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (!stat.scan_done)
                begin
                    scan_cls_reg <= scan_reg;
                    scan_rd_reg  <= 1'b1;
                    if (scan_reg != CW'(gsca_pkg::NUM_CLASSES - 1))
                    begin
                        scan_reg <= scan_reg + CW'(1);
                    end
                end
                else
                begin
                    scan_rd_reg <= 1'b0;
                end
                if (scan_rd_reg && count_reg[scan_cls_reg] != '0 &&
                    (!found_reg || age > best_age_reg))
                begin
                    found_reg    <= 1'b1;
                    best_reg     <= scan_cls_reg;
                    best_age_reg <= age;
                end
            end
            if (cmd.ev_do)
            begin
                total_reg <= (32'(prod_reg) > total_reg) ? 32'd0 :
                             total_reg - 32'(prod_reg);
                evc_reg   <= evc_reg + gsca_pkg::EVC_W'(1);
                if (count_reg[best_reg] == NW'(1))
                begin
                    head_reg[best_reg] <= '0;
                    used_reg[best_reg] <= '0;
                end
                else
                begin
                    head_reg[best_reg] <= ring(head_reg[best_reg], NW'(1));
                end
                count_reg[best_reg] <= count_reg[best_reg] - NW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            w_reg   <= in_width;
            h_reg   <= in_height;
            cls_reg <= gsca_pkg::height_class(in_height);
        end
        if (cmd.ev_mul)
        begin
            prod_reg <= rd_w * rd_h;
        end
        if (cmd.alloc_do)
        begin
            if (fits)
            begin
                res_status <= gsca_pkg::ST_EXISTING;
                res_number <= rd_id;
                res_x      <= used_reg[cls_reg];
                res_w      <= rd_w;
                res_h      <= rd_h;
            end
            else if (full)
            begin
                res_status <= gsca_pkg::ST_FULL;
                res_number <= '0;
                res_x      <= '0;
                res_w      <= '0;
                res_h      <= '0;
            end
            else
            begin
                res_status <= gsca_pkg::ST_NEW;
                res_number <= next_num_reg;
                res_x      <= '0;
                res_w      <= new_w;
                res_h      <= new_h;
            end
        end
        if (cmd.ev_mul)
        begin
            res_status <= gsca_pkg::ST_EVICTED;
            res_number <= rd_id;
            res_x      <= '0;
            res_w      <= rd_w;
            res_h      <= rd_h;
        end
        if (cmd.res_none || cmd.res_clear)
        begin
            res_status <= cmd.res_clear ? gsca_pkg::ST_CLEARED : gsca_pkg::ST_NONE;
            res_number <= '0;
            res_x      <= '0;
            res_w      <= '0;
            res_h      <= '0;
        end
    end

endmodule

[rtl/glyph_shelf_cache_allocator.sv]
// Top level of the glyph shelf cache allocator: stream ports around the
// controller and datapath. Depends on gsca_pkg, gsca_ctrl, gsca_dp, gsca_ram.
//
// One beat is taken at a time. An allocate reads the newest shelf of its class
// from the store and then decides and updates; a clear goes straight to its
// result, and an enforce with nothing to evict checks the limit and gives its
// result. An enforce that evicts checks the limit up front and then, for each
// evicted shelf, scans the ten class heads through the store's registered read
// port, reads the head entry, multiplies the area and retires the shelf. Each
// result is held in the output register until taken; a new beat is accepted
// once the last result of the item has gone.
module glyph_shelf_cache_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // func
    input  logic [23:0] s_tdata,   // glyph_width[10:0], glyph_height[22:11], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tlast,   // last
    output logic [71:0] m_tdata    // status[2:0], shelf_number[34:3], x_offset[45:35],
                                   // shelf_width[56:46], shelf_height[68:57], zero pad
);

    gsca_pkg::dp_cmd_t  cmd;
    gsca_pkg::dp_stat_t stat;
    logic [2:0]  res_status;
    logic [31:0] res_number;
    logic [10:0] res_x, res_w;
    logic [11:0] res_h;

    gsca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_last  (m_tlast),
        .stat      (stat),
        .cmd       (cmd)
    );

    gsca_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_func    (s_tuser),
        .in_width   (s_tdata[10:0]),
        .in_height  (s_tdata[22:11]),
        .cmd        (cmd),
        .stat       (stat),
        .res_status (res_status),
        .res_number (res_number),
        .res_x      (res_x),
        .res_w      (res_w),
        .res_h      (res_h)
    );

    assign m_tdata = {3'b000, res_h, res_w, res_x, res_number, res_status};

endmodule
